FILE: hw/rtl/mmsb_pkg.sv
package mmsb_pkg;

  // Operation codes carried in tuser
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_BLIT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  // Linear canvas byte address; covers the largest canvas store
  localparam int LIN_W = 21;
  // Compare width for sprite pixel positions against the clamped sprite width
  localparam int SW_CMP_W = 13;

  localparam logic [10:0] CANVAS_WIDTH_RST  = 11'd256;
  localparam logic [8:0]  CANVAS_HEIGHT_RST = 9'd192;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic calc;       // compute blit addresses and masks
    logic wr_host;    // store write_data at canvas_addr
    logic rd_host;    // read canvas_addr
    logic rd_a;       // read first blit byte
    logic wr_a_rd_b;  // write back first byte, read second
    logic wr_b;       // write back second byte
    logic out_load;   // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
  } dp_sts_t;

endpackage

FILE: hw/rtl/masked_mono_sprite_blitter_core.sv
// 1-bpp canvas held in an internal byte memory, packed MSB first, each row
// padded to a multiple of 32 pixels (4 bytes per 32 pixels of canvas width).
// tuser selects the operation: write a
// canvas byte, blit one masked sprite byte, or read a canvas byte; every item
// returns one result byte (the canvas byte on a read, zero otherwise). Items
// are handled one at a time: a write, a read or an unused code goes through the
// decode and done states before the next acceptance; a blit adds the
// read-modify-write of the two canvas bytes an unaligned sprite byte covers
// through the single memory with registered read data. A result waiting on
// the output does not hold off the next item until that item completes. The
// canvas has no reset: bytes must be written before they are read or blitted
// over. Configuration is accepted every cycle and must only change while idle.
module masked_mono_sprite_blitter_core #(
  parameter int MAX_CANVAS_BYTES = 32768,
  parameter int MAX_SPRITE_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // canvas_addr[14:0], write_data[22:15], sprite_byte[30:23], mask_byte[38:31],
  // origin_x[50:39], origin_y[62:51], sprite_row[72:63], byte_column[79:73],
  // sprite_width[90:80], invert_mode[91], zero[95:92]
  input  logic [mmsb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [mmsb_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // read_data[7:0]
  output logic [mmsb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [mmsb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mmsb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mmsb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mmsb_dp #(
    .MAX_CANVAS_BYTES (MAX_CANVAS_BYTES),
    .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

FILE: hw/rtl/mmsb_dp.sv
module mmsb_dp #(
  parameter int MAX_CANVAS_BYTES = 32768,
  parameter int MAX_SPRITE_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mmsb_pkg::dp_cmd_t                    cmd,
  output mmsb_pkg::dp_sts_t                    sts,
  input  logic [mmsb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [mmsb_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_index,
  input  logic [mmsb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [mmsb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import mmsb_pkg::*;

  localparam int MEM_AW = (MAX_CANVAS_BYTES > 1) ? $clog2(MAX_CANVAS_BYTES) : 1;
  localparam logic [LIN_W-1:0] MAX_BYTES = LIN_W'(MAX_CANVAS_BYTES);
  localparam logic [SW_CMP_W-1:0] SW_LIMIT = SW_CMP_W'(MAX_SPRITE_WIDTH);

  function automatic logic [7:0] merge(input logic [7:0] old_b, input logic [7:0] m,
                                       input logic [7:0] ink, input logic inv);
    if (inv) begin
      merge = old_b ^ (m & ink);
    end else begin
      merge = (old_b & ~m) | (m & ink);
    end
  endfunction

  // Item fields
  logic [1:0]         func_r;
  logic [14:0]        haddr_r;
  logic [7:0]         wdata_r;
  logic [7:0]         ink_r;
  logic [7:0]         opq_r;
  logic [11:0]        ox_r;
  logic [11:0]        oy_r;
  logic [9:0]         row_r;
  logic [6:0]         col_r;
  logic [10:0]        sw_r;
  logic               inv_r;

  // Configuration
  logic [10:0]        cw_r;
  logic [8:0]         ch_r;

  // Blit work registers
  logic [LIN_W-1:0]   addr_a_r, addr_b_r;
  logic [7:0]         ma_r, mb_r, ia_r, ib_r;

  logic [7:0]         rdata_r;
  logic [7:0]         out_data_r;
  logic [7:0]         mem [MAX_CANVAS_BYTES];

  // Blit decode
  logic [12:0]        y;
  logic               y_ok;
  logic [12:0]        x0;
  logic [11:0]        cw_ext;
  logic [8:0]         stride;
  logic [SW_CMP_W-1:0] sw_c;
  logic [7:0]         en8;
  logic [15:0]        win_m, win_i;
  logic [9:0]         col_b;
  logic [17:0]        prod;
  logic [LIN_W-1:0]   addr_a, addr_b;
  logic               ok_a, ok_b;
  logic               host_ok;
  logic [LIN_W-1:0]   host_lin;

  logic               mem_we;
  logic [LIN_W-1:0]   mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;

  assign sts.func  = func_r;
  assign out_tdata = out_data_r;
  assign host_lin  = LIN_W'(haddr_r);
  assign host_ok   = host_lin < MAX_BYTES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= CANVAS_WIDTH_RST;
      ch_r <= CANVAS_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  cw_r <= cfg_data;
        REG_CANVAS_HEIGHT: ch_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_tuser;
      haddr_r <= in_tdata[14:0];
      wdata_r <= in_tdata[22:15];
      ink_r   <= in_tdata[30:23];
      opq_r   <= in_tdata[38:31];
      ox_r    <= in_tdata[50:39];
      oy_r    <= in_tdata[62:51];
      row_r   <= in_tdata[72:63];
      col_r   <= in_tdata[79:73];
      sw_r    <= in_tdata[90:80];
      inv_r   <= in_tdata[91];
    end
  end

  always_comb begin
    logic [12:0]         xb;
    logic [SW_CMP_W-1:0] px;
    y      = {oy_r[11], oy_r} + {3'b000, row_r};
    y_ok   = !y[12] && (y[11:0] < {3'b000, ch_r});
    x0     = {ox_r[11], ox_r} + {3'b000, col_r, 3'b000};
    cw_ext = {1'b0, cw_r} + 12'd31;
    stride = {cw_ext[11:5], 2'b00};
    sw_c   = (SW_CMP_W'(sw_r) > SW_LIMIT) ? SW_LIMIT : SW_CMP_W'(sw_r);
    en8    = '0;
    for (int b = 0; b < 8; b++) begin
      xb = x0 + 13'(b);
      px = SW_CMP_W'({col_r, 3'b000}) + SW_CMP_W'(b);
      en8[7-b] = opq_r[7-b] && (px < sw_c) && !xb[12] && (xb[11:0] < {1'b0, cw_r});
    end
    // Two canvas bytes under the sprite byte, left one in the upper half
    win_m  = {en8, 8'h00} >> x0[2:0];
    win_i  = {ink_r, 8'h00} >> x0[2:0];
    col_b  = x0[12:3] + 10'd1;
    prod   = y[8:0] * stride;
    addr_a = LIN_W'(prod) + LIN_W'(x0[11:3]);
    addr_b = LIN_W'(prod) + LIN_W'(col_b[8:0]);
    ok_a   = y_ok && (addr_a < MAX_BYTES);
    ok_b   = y_ok && (addr_b < MAX_BYTES);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr_a_r <= addr_a;
      addr_b_r <= addr_b;
      ma_r     <= ok_a ? win_m[15:8] : 8'h00;
      mb_r     <= ok_b ? win_m[7:0] : 8'h00;
      ia_r     <= win_i[15:8];
      ib_r     <= win_i[7:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = host_lin;
    mem_wdata = wdata_r;
    mem_raddr = host_lin;
    mem_re    = cmd.rd_host;
    if (cmd.wr_host) begin
      mem_we = host_ok;
    end
    if (cmd.rd_a) begin
      mem_raddr = addr_a_r;
      mem_re    = 1'b1;
    end
    if (cmd.wr_a_rd_b) begin
      mem_we    = |ma_r;
      mem_waddr = addr_a_r;
      mem_wdata = merge(rdata_r, ma_r, ia_r, inv_r);
      mem_raddr = addr_b_r;
      mem_re    = 1'b1;
    end
    if (cmd.wr_b) begin
      mem_we    = |mb_r;
      mem_waddr = addr_b_r;
      mem_wdata = merge(rdata_r, mb_r, ib_r, inv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[MEM_AW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (func_r == FUNC_READ && host_ok) ? rdata_r : 8'h00;
    end
  end

endmodule

FILE: hw/rtl/mmsb_ctrl.sv
module mmsb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output mmsb_pkg::dp_cmd_t  cmd,
  input  mmsb_pkg::dp_sts_t  sts
);
  import mmsb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_RDA  = 3'd2;
  localparam logic [2:0] S_WRA  = 3'd3;
  localparam logic [2:0] S_WRB  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        case (sts.func)
          FUNC_WRITE: begin
            cmd.wr_host = 1'b1;
            state_nxt   = S_DONE;
          end
          FUNC_READ: begin
            cmd.rd_host = 1'b1;
            state_nxt   = S_DONE;
          end
          FUNC_BLIT: state_nxt = S_RDA;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_WRA;
      end
      S_WRA: begin
        cmd.wr_a_rd_b = 1'b1;
        state_nxt     = S_WRB;
      end
      S_WRB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the result slot to drain
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CALC))
    else $error("accepted item did not start decode");

  a_blit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRB) |-> ($past(state_r) == S_WRA && $past(state_r, 2) == S_RDA))
    else $error("second byte written out of order");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

endmodule
